// ----- hw/rtl/rgbhsv_pkg.sv -----
// Package for the RGB to HSV converter: widths, hue constants and the
// record that travels down the divider chain. No dependencies.

package rgbhsv_pkg;

  localparam int unsigned CH_W   = 8;   // one color channel
  localparam int unsigned HUE_W  = 11;  // hue, full turn of 1536
  localparam int unsigned QUO_W  = 9;   // quotient bits, one per cell
  localparam int unsigned NUM_W  = CH_W + QUO_W;  // dividend width
  localparam int unsigned N_CELLS = QUO_W;

  localparam logic [HUE_W-1:0] HUE_TURN  = 11'd1536;
  localparam logic [HUE_W-1:0] HUE_GREEN = 11'd512;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 11'd1024;

  // One restoring division in flight: partial remainder, dividend bits
  // still to be brought down, divisor and the quotient collected so far.
  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] low;
    logic [CH_W-1:0]  div;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    div_t             sat;
    div_t             hue;
    logic [HUE_W-1:0] base;
    logic             neg;
    logic             grey;
    logic [CH_W-1:0]  value;
  } cell_t;

endpackage

// ----- hw/rtl/rgbhsv_rgb_if.sv -----
// Input channel of the RGB to HSV converter: one pixel per item.
// Depends on rgbhsv_pkg.

interface rgbhsv_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rgbhsv_pkg::CH_W-1:0] red;
  logic [rgbhsv_pkg::CH_W-1:0] green;
  logic [rgbhsv_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/rgbhsv_hsv_if.sv -----
// Output channel of the RGB to HSV converter: one HSV result per item.
// Depends on rgbhsv_pkg.

interface rgbhsv_hsv_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsv_pkg::HUE_W-1:0] hue;
  logic [rgbhsv_pkg::CH_W-1:0]  saturation;
  logic [rgbhsv_pkg::CH_W-1:0]  value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ----- hw/rtl/rgbhsv_prep.sv -----
// Front stage: finds max, min and chroma, picks the hue sector and sets up
// both dividends for the cell chain. Depends on rgbhsv_pkg.

module rgbhsv_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rgbhsv_pkg::CH_W-1:0] red_i,
  input  logic [rgbhsv_pkg::CH_W-1:0] green_i,
  input  logic [rgbhsv_pkg::CH_W-1:0] blue_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output rgbhsv_pkg::cell_t           data_o,
  input  logic                        ready_i
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0]  mx, mn, d, p, q, a;
  logic [HUE_W-1:0] base;
  logic             neg;
  logic [NUM_W-1:0] hue_num, sat_num;
  cell_t            data_d, data_q;
  logic             valid_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;

    // Ties go to red first, then green.
    if (mx == red_i) begin
      p = green_i; q = blue_i; base = HUE_TURN;
    end else if (mx == green_i) begin
      p = blue_i; q = red_i; base = HUE_GREEN;
    end else begin
      p = red_i; q = green_i; base = HUE_BLUE;
    end
    neg = p < q;
    a   = neg ? q - p : p - q;

    // A negative offset is subtracted as a ceiling, so d - 1 is added first.
    hue_num = {1'b0, a, 8'd0} + (neg ? NUM_W'(d) - NUM_W'(1) : '0);
    sat_num = {1'b0, d, 8'd0} - NUM_W'(d);

    data_d.sat.rem = sat_num[NUM_W-1 -: CH_W];
    data_d.sat.low = sat_num[QUO_W-1:0];
    data_d.sat.div = mx;
    data_d.sat.quo = '0;
    data_d.hue.rem = hue_num[NUM_W-1 -: CH_W];
    data_d.hue.low = hue_num[QUO_W-1:0];
    data_d.hue.div = d;
    data_d.hue.quo = '0;
    data_d.base    = base;
    data_d.neg     = neg;
    data_d.grey    = (d == '0);
    data_d.value   = mx;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/rgbhsv_cell.sv -----
// One divider cell: brings down one dividend bit and settles one quotient
// bit for both the saturation and the hue division. Depends on rgbhsv_pkg.

module rgbhsv_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rgbhsv_pkg::cell_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output rgbhsv_pkg::cell_t data_o,
  input  logic              ready_i
);
  import rgbhsv_pkg::*;

  function automatic div_t div_step(div_t x);
    logic [CH_W:0] trial;
    logic          take;
    div_t          y;
    trial  = {x.rem, x.low[QUO_W-1]};
    take   = trial >= {1'b0, x.div};
    y      = x;
    y.rem  = take ? CH_W'(trial - {1'b0, x.div}) : trial[CH_W-1:0];
    y.low  = {x.low[QUO_W-2:0], 1'b0};
    y.quo  = {x.quo[QUO_W-2:0], take};
    return y;
  endfunction

  cell_t data_d, data_q;
  logic  valid_q;

  always_comb begin
    data_d     = data_i;
    data_d.sat = div_step(data_i.sat);
    data_d.hue = div_step(data_i.hue);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front stage, a chain of divider
// cells and the output register. Depends on rgbhsv_pkg, the two channel
// interfaces, rgbhsv_prep and rgbhsv_cell.
//
//   port    direction  item
//   rgb_i   sink       red, green, blue (8 bits each)
//   hsv_o   source     hue (11 bits), saturation (8 bits), value (8 bits)
//
// One pixel is taken every clock unless a stall on hsv_o has filled the stages;
// a result passes through the front register, the nine divider cells, one
// quotient bit each, and the output register after them.
// Reset clears the valid flags of all stages; no data is cleared.
// A stall on hsv_o holds each full stage, while empty stages ahead still fill.

module rgb_to_hsv_converter (
  input logic         clk_i,
  input logic         rst_ni,
  rgbhsv_rgb_if.sink   rgb_i,
  rgbhsv_hsv_if.source hsv_o
);
  import rgbhsv_pkg::*;

  logic  valid_s [N_CELLS+1];
  logic  ready_s [N_CELLS+1];
  cell_t data_s  [N_CELLS+1];

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rgb_i.valid),
    .red_i   (rgb_i.red),
    .green_i (rgb_i.green),
    .blue_i  (rgb_i.blue),
    .ready_o (rgb_i.ready),
    .valid_o (valid_s[0]),
    .data_o  (data_s[0]),
    .ready_i (ready_s[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .data_i  (data_s[i]),
      .ready_o (ready_s[i]),
      .valid_o (valid_s[i+1]),
      .data_o  (data_s[i+1]),
      .ready_i (ready_s[i+1])
    );
  end

  cell_t            last;
  logic [HUE_W:0]   hue_sum;
  logic [HUE_W-1:0] hue_d, hue_q;
  logic [CH_W-1:0]  sat_d, sat_q, value_q;
  logic             out_valid_q;

  assign last = data_s[N_CELLS];
  assign ready_s[N_CELLS] = !out_valid_q || hsv_o.ready;

  always_comb begin
    hue_sum = last.neg ? {1'b0, last.base} - (HUE_W+1)'(last.hue.quo)
                       : {1'b0, last.base} + (HUE_W+1)'(last.hue.quo);
    // Only the red sector can pass a full turn; fold it back.
    if (hue_sum >= {1'b0, HUE_TURN}) begin
      hue_sum = hue_sum - {1'b0, HUE_TURN};
    end
    hue_d = last.grey ? '0 : hue_sum[HUE_W-1:0];
    sat_d = last.grey ? '0 : last.sat.quo[CH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_s[N_CELLS]) begin
      out_valid_q <= valid_s[N_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s[N_CELLS] && valid_s[N_CELLS]) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= last.value;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = value_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for rgb_to_hsv_converter: pixels go in through the
// rgbhsv_rgb_if channel and each HSV result is checked against a local model.
// Depends on rgbhsv_pkg, rgbhsv_rgb_if, rgbhsv_hsv_if and the converter RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhsv_pkg::*;

  localparam int unsigned PIXELS_PER_PHASE = 410;
  localparam int unsigned QUIET_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES     = 24;
  localparam int unsigned STALL_AT         = 300;
  localparam int unsigned STALL_CYCLES     = 90;
  localparam int unsigned N_PRESET         = 23;

  // Corner pixels as {red, green, blue}.
  localparam logic [3*CH_W-1:0] PRESET [N_PRESET] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
    24'h010000, 24'h000100, 24'h000001, 24'hFFFE00, 24'h00FEFF, 24'hFE00FF,
    24'hC86432, 24'h3264C8, 24'h64C832, 24'hFF807F, 24'h010001
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value;
  } hsv_t;

  logic clk;
  logic rst_n;

  rgbhsv_rgb_if rgb ();
  rgbhsv_hsv_if hsv ();

  rgb_to_hsv_converter dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rgb_i (rgb),
    .hsv_o (hsv)
  );

  pixel_t      pixel_queue[$];
  hsv_t        hsv_expect[$];
  bit          pixel_on_bus;
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pixels_in;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned quiet;
  int unsigned stall_left;
  bit          stall_done;

  always #2 clk = ~clk;

  // Signed floor(256 * (p - q) / span); the negative side rounds away from zero.
  function automatic int sixth_step(int unsigned p, int unsigned q, int unsigned span);
    if (p >= q) return int'((256 * (p - q)) / span);
    return -int'((256 * (q - p) + span - 1) / span);
  endfunction

  function automatic hsv_t hsv_of(pixel_t px);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned top;
    int unsigned bot;
    int unsigned span;
    int          h;
    hsv_t        res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = r;
    bot = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bot) bot = g;
    if (b < bot) bot = b;
    span = top - bot;
    res.value = CH_W'(top);
    res.saturation = (top == 0) ? '0 : CH_W'((255 * span) / top);
    if (span == 0) begin
      h = 0;
    end else if (top == r) begin
      h = int'(HUE_TURN) + sixth_step(g, b, span);
      if (h >= int'(HUE_TURN)) h -= int'(HUE_TURN);
    end else if (top == g) begin
      h = int'(HUE_GREEN) + sixth_step(b, r, span);
    end else begin
      h = int'(HUE_BLUE) + sixth_step(r, g, span);
    end
    res.hue = HUE_W'(h);
    return res;
  endfunction

  // Uniform pixels four draws in ten; else greys, two tied channels, extreme and near-equal mixes.
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned lvl;
    px.red   = CH_W'($urandom);
    px.green = CH_W'($urandom);
    px.blue  = CH_W'($urandom);
    case ($urandom_range(9, 0))
      4: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      5: begin
        case ($urandom_range(2, 0))
          0: px.green = px.red;
          1: px.blue = px.green;
          default: px.blue = px.red;
        endcase
      end
      6: begin
        px.red   = CH_W'(($urandom_range(1, 0) ? 255 : 0) ^ $urandom_range(1, 0));
        px.green = CH_W'(($urandom_range(1, 0) ? 255 : 0) ^ $urandom_range(1, 0));
        px.blue  = CH_W'(($urandom_range(1, 0) ? 255 : 0) ^ $urandom_range(1, 0));
      end
      7: begin
        px.red   = CH_W'($urandom_range(3, 0));
        px.green = CH_W'($urandom_range(3, 0));
        px.blue  = CH_W'($urandom_range(3, 0));
      end
      8: begin
        lvl = $urandom_range(254, 1);
        px.red   = CH_W'(lvl - 1 + $urandom_range(2, 0));
        px.green = CH_W'(lvl - 1 + $urandom_range(2, 0));
        px.blue  = CH_W'(lvl - 1 + $urandom_range(2, 0));
      end
      9: begin
        px.red   = 8'hFF;
        px.green = 8'h00;
        if ($urandom_range(1, 0)) px = '{px.blue, px.red, px.green};
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH %s in result %0d: got %0d, expected %0d",
               field, results_seen, got, want);
  endtask

  // Pixel driver: holds an offered item until it is taken, else may idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      rgb.valid <= 1'b0;
    end else if (!pixel_on_bus) begin
      if (pixel_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        pixel_t px;
        px = pixel_queue.pop_front();
        rgb.red      <= px.red;
        rgb.green    <= px.green;
        rgb.blue     <= px.blue;
        rgb.valid    <= 1'b1;
        pixel_on_bus = 1'b1;
      end else begin
        rgb.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus one long stall that fills the pipe.
  always @(negedge clk) begin
    if (!rst_n) begin
      hsv.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      hsv.ready <= 1'b0;
    end else if (!stall_done && results_seen >= STALL_AT) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES - 1;
      hsv.ready <= 1'b0;
    end else begin
      hsv.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    pixel_t px;
    hsv_t   want;
    bit     moved;
    moved = 1'b0;
    if (rst_n && rgb.valid && rgb.ready) begin
      px = '{rgb.red, rgb.green, rgb.blue};
      hsv_expect.push_back(hsv_of(px));
      pixels_in++;
      pixel_on_bus = 1'b0;
      moved = 1'b1;
    end
    if (rst_n && hsv.valid && hsv.ready) begin
      results_seen++;
      moved = 1'b1;
      if (hsv_expect.size() == 0) begin
        report_mismatch("unexpected result, hue", int'(hsv.hue), -1);
      end else begin
        want = hsv_expect.pop_front();
        if (hsv.hue !== want.hue)
          report_mismatch("hue", int'(hsv.hue), int'(want.hue));
        if (hsv.saturation !== want.saturation)
          report_mismatch("saturation", int'(hsv.saturation), int'(want.saturation));
        if (hsv.value !== want.value)
          report_mismatch("value", int'(hsv.value), int'(want.value));
      end
    end
    quiet = moved ? 0 : quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    rgb.valid = 1'b0;
    rgb.red   = '0;
    rgb.green = '0;
    rgb.blue  = '0;
    hsv.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Three idling mixes; between them the sender waits for the pipe to drain.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
      recv_idle_pct   = (phase == 0) ? 57 : (phase == 1) ? 37 : 0;
      if (phase == 0)
        for (int i = 0; i < N_PRESET; i++) pixel_queue.push_back(pixel_t'(PRESET[i]));
      repeat (PIXELS_PER_PHASE) pixel_queue.push_back(random_pixel());
      while (pixel_queue.size() != 0 || pixel_on_bus) @(posedge clk);
      while (hsv_expect.size() != 0) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d pixels (%0d corner cases) under three",
             results_seen, pixels_in, N_PRESET);
    $display("idling mixes and one %0d-cycle output stall", STALL_CYCLES);
    if (errors == 0 && hsv_expect.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
